// ----- rtl/scbc_pkg.sv -----
package scbc_pkg;

	localparam int DefaultMaxRanges = 32;
	localparam int DefaultSectorBlocks = 128;
	localparam int RoundCount = 10;

	localparam logic [2:0] RegKeyHigh = 3'd0;
	localparam logic [2:0] RegKeyLow = 3'd1;
	localparam logic [2:0] RegRegionCount = 3'd2;
	localparam logic [2:0] RegInvalid = 3'd7;

	typedef struct packed {
		logic load_chain;   // start of an item: pick chain, add round key 0
		logic do_round;     // one AES round
		logic last_round;   // round without MixColumns
		logic take_plain;   // result is the plaintext
		logic key_start;    // restart key expansion
		logic key_step;     // one key schedule step
	} scbc_cmd_t;

	typedef struct packed {
		logic key_busy;
	} scbc_stat_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

// ----- rtl/scbc_ctrl.sv -----
module scbc_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     mode,
	input  logic                     is_plain,
	output logic                     out_valid,
	input  logic                     out_ready,
	input  logic                     key_write,
	input  scbc_pkg::scbc_stat_t     stat,
	output scbc_pkg::scbc_cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOOK  = 4'b0010,
		ST_ROUND = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t state_q;
	logic [3:0] round_q;

	// No item is taken in the cycle that restarts the key schedule either.
	assign in_ready = (state_q == ST_IDLE) && !stat.key_busy && !key_write;
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd = '0;
		cmd.key_start = key_write;
		cmd.key_step = stat.key_busy;
		cmd.load_chain = (state_q == ST_LOOK) && !is_plain;
		cmd.take_plain = (state_q == ST_LOOK) && is_plain;
		cmd.do_round = (state_q == ST_ROUND);
		cmd.last_round = (state_q == ST_ROUND) && (round_q == 4'(scbc_pkg::RoundCount));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready && mode) state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					round_q <= 4'd1;
					state_q <= is_plain ? ST_OUT : ST_ROUND;
				end
				ST_ROUND: begin
					round_q <= round_q + 4'd1;
					if (round_q == 4'(scbc_pkg::RoundCount)) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/scbc_datapath.sv -----
module scbc_datapath #(
	parameter int MAX_RANGES = scbc_pkg::DefaultMaxRanges,
	parameter int SECTOR_BLOCKS = scbc_pkg::DefaultSectorBlocks
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  scbc_pkg::scbc_cmd_t     cmd,
	output scbc_pkg::scbc_stat_t    stat,
	input  logic                    accept,
	input  logic                    mode,
	input  logic [4:0]              region_index,
	input  logic [31:0]             range_first,
	input  logic [31:0]             range_last,
	input  logic [31:0]             sector_number,
	input  logic [6:0]              block_index,
	input  logic [63:0]             data_high,
	input  logic [63:0]             data_low,
	input  logic [127:0]            key,
	input  logic [5:0]              region_count,
	output logic                    is_plain,
	output logic [63:0]             out_high,
	output logic [63:0]             out_low,
	output logic                    passed_plain,
	output logic                    sector_done
);

	localparam int IdxW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

	// Range table: registers, compared in parallel (MAX_RANGES entries, 32 by default).
	logic [31:0] first_q [MAX_RANGES];
	logic [31:0] last_q [MAX_RANGES];

	logic [127:0] in_q;
	logic [31:0] sector_q;
	logic [6:0] bidx_q;
	logic [127:0] chain_q, state_q;
	logic [127:0] rk_q [11];
	logic [127:0] kw_q;
	logic [3:0] kstep_q;
	logic kbusy_q;
	logic [7:0] rcon_q;
	logic [3:0] rnd_q;

	assign stat.key_busy = kbusy_q;

	always_ff @(posedge clk) begin
		if (accept && !mode && (int'(region_index) < MAX_RANGES)) begin
			first_q[IdxW'(region_index)] <= range_first;
			last_q[IdxW'(region_index)] <= range_last;
		end
		if (accept) begin
			in_q <= {data_high, data_low};
			sector_q <= sector_number;
			bidx_q <= block_index;
		end
	end

	always_comb begin
		logic [6:0] cnt;
		cnt = (region_count > 6'(MAX_RANGES > 63 ? 63 : MAX_RANGES)) ?
			7'(MAX_RANGES > 63 ? 63 : MAX_RANGES) : {1'b0, region_count};
		is_plain = 1'b0;
		for (int i = 0; i < MAX_RANGES; i++) begin
			if (i < int'(cnt) && sector_q >= first_q[i] && sector_q <= last_q[i])
				is_plain = 1'b1;
		end
	end

	// Key schedule: one round key per cycle after reset or a key write.
	function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		t = {scbc_pkg::sbox(w3[23:16]) ^ rc, scbc_pkg::sbox(w3[15:8]),
			scbc_pkg::sbox(w3[7:0]), scbc_pkg::sbox(w3[31:24])};
		w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kbusy_q <= 1'b1;
			kstep_q <= '0;
			kw_q <= '0;
			rcon_q <= 8'h01;
		end else if (cmd.key_start) begin
			kbusy_q <= 1'b1;
			kstep_q <= '0;
			kw_q <= key;
			rcon_q <= 8'h01;
		end else if (cmd.key_step) begin
			kstep_q <= kstep_q + 4'd1;
			if (kstep_q != 4'd0) begin
				kw_q <= key_next(kw_q, rcon_q);
				rcon_q <= scbc_pkg::xtime(rcon_q);
			end
			if (kstep_q == 4'(scbc_pkg::RoundCount)) kbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.key_step) begin
			rk_q[kstep_q] <= (kstep_q == 4'd0) ? kw_q : key_next(kw_q, rcon_q);
		end
	end

	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) b[i] = scbc_pkg::sbox(s[127-8*i -: 8]);
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++) t[i+4*c] = b[i + 4*((c+i)%4)];
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				al = a0 ^ a1 ^ a2 ^ a3;
				t[4*c]   = a0 ^ al ^ scbc_pkg::xtime(a0 ^ a1);
				t[4*c+1] = a1 ^ al ^ scbc_pkg::xtime(a1 ^ a2);
				t[4*c+2] = a2 ^ al ^ scbc_pkg::xtime(a2 ^ a3);
				t[4*c+3] = a3 ^ al ^ scbc_pkg::xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
			state_q <= '0;
			rnd_q <= '0;
			passed_plain <= 1'b0;
			sector_done <= 1'b0;
		end else begin
			if (cmd.load_chain) begin
				state_q <= in_q ^ ((bidx_q == 7'd0) ? {96'd0, sector_q} : chain_q) ^ rk_q[0];
				rnd_q <= 4'd1;
			end else if (cmd.do_round) begin
				state_q <= aes_round(state_q, cmd.last_round) ^ rk_q[rnd_q];
				rnd_q <= rnd_q + 4'd1;
				if (cmd.last_round)
					chain_q <= aes_round(state_q, 1'b1) ^ rk_q[rnd_q];
			end else if (cmd.take_plain) begin
				state_q <= in_q;
			end
			if (cmd.load_chain || cmd.take_plain) begin
				passed_plain <= cmd.take_plain;
				sector_done <= ({25'd0, bidx_q} == 32'(SECTOR_BLOCKS - 1));
			end
		end
	end

	assign out_high = state_q[127:64];
	assign out_low = state_q[63:0];

endmodule

// ----- rtl/sector_cbc_encryptor_with_plain_ranges_unit.sv -----
// AES-128 CBC sector encryptor. Each data item (mode 1) carries one 16-byte
// block; its result item is valid after the plain-range look-up together with
// the initial key addition, then ten AES rounds on a single round unit, and the
// next item is taken once that result has been handed over. A block of a plain
// sector gives its result after the look-up alone, with no rounds. A mode-0
// item writes a range-table entry and gives no result. After reset the round
// keys are expanded, and after every write of key_high or key_low the input is
// held off while they are expanded again. Sectors in any of the first
// region_count ranges pass through unchanged with passed_plain set and
// leave the chain value alone.
module sector_cbc_encryptor_with_plain_ranges_unit #(
	parameter int MAX_RANGES = scbc_pkg::DefaultMaxRanges,
	parameter int SECTOR_BLOCKS = scbc_pkg::DefaultSectorBlocks
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [4:0]  region_index,
	input  logic [31:0] range_first,
	input  logic [31:0] range_last,
	input  logic [31:0] sector_number,
	input  logic [6:0]  block_index,
	input  logic [63:0] data_high,
	input  logic [63:0] data_low,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_high,
	output logic [63:0] out_low,
	output logic        passed_plain,
	output logic        sector_done
);

	logic [63:0] key_high_q, key_low_q;
	logic [5:0] region_count_q;
	logic wr, key_write, is_plain;
	logic [2:0] reg_idx;
	scbc_pkg::scbc_cmd_t cmd;
	scbc_pkg::scbc_stat_t stat;

	// Registers lie at byte addresses 0, 8 and 16.
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign reg_idx = paddr[4:3] == 2'd0 ? scbc_pkg::RegKeyHigh :
		paddr[4:3] == 2'd1 ? scbc_pkg::RegKeyLow :
		paddr[4:3] == 2'd2 ? scbc_pkg::RegRegionCount : scbc_pkg::RegInvalid;
	assign key_write = wr && (reg_idx == scbc_pkg::RegKeyHigh || reg_idx == scbc_pkg::RegKeyLow);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			region_count_q <= '0;
		end else if (wr) begin
			case (reg_idx)
				scbc_pkg::RegKeyHigh: key_high_q <= pwdata;
				scbc_pkg::RegKeyLow: key_low_q <= pwdata;
				scbc_pkg::RegRegionCount: region_count_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			scbc_pkg::RegKeyHigh: prdata = key_high_q;
			scbc_pkg::RegKeyLow: prdata = key_low_q;
			scbc_pkg::RegRegionCount: prdata = {58'd0, region_count_q};
			default: prdata = '0;
		endcase
	end

	// The key is taken from the registers in the cycle after the write lands.
	logic key_write_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) key_write_q <= 1'b0;
		else key_write_q <= key_write;
	end

	scbc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .is_plain(is_plain), .out_valid(out_valid), .out_ready(out_ready),
		.key_write(key_write_q), .stat(stat), .cmd(cmd)
	);

	scbc_datapath #(.MAX_RANGES(MAX_RANGES), .SECTOR_BLOCKS(SECTOR_BLOCKS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.accept(in_valid && in_ready), .mode(mode), .region_index(region_index),
		.range_first(range_first), .range_last(range_last),
		.sector_number(sector_number), .block_index(block_index),
		.data_high(data_high), .data_low(data_low),
		.key({key_high_q, key_low_q}), .region_count(region_count_q),
		.is_plain(is_plain), .out_high(out_high), .out_low(out_low),
		.passed_plain(passed_plain), .sector_done(sector_done)
	);

endmodule
